@@ hdl/sprs_pkg.sv @@
// Shared types and constants for the sparse point range-sum block.
// Used by sprs_cell, sparse_point_range_sum_top and sprs_chk; no dependencies.
package sprs_pkg;

    // store geometry
    localparam int MAX_POINTS = 1024;
    localparam int N_CELLS    = 8;                      // must divide MAX_POINTS
    localparam int BANK_D     = MAX_POINTS / N_CELLS;   // entries per cell, power of two
    localparam int ADDR_W     = $clog2(BANK_D);
    localparam int LIM_W      = $clog2(BANK_D + 1);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SEL_W      = CNT_W - ADDR_W;

    // field widths
    localparam int COORD_W = 32;
    localparam int VAL_W   = 42;
    localparam int SUM_W   = 43;
    localparam int ACC_W   = VAL_W + $clog2(MAX_POINTS);
    localparam int STAT_W  = 2;

    // stream word widths
    localparam int IN_DATA_W  = 3 * COORD_W;
    localparam int OUT_DATA_W = ((SUM_W + 7) / 8) * 8;

    // saturation bounds
    localparam logic [VAL_W:0] VAL_MAX_X = {2'b00, {(VAL_W - 1){1'b1}}};
    localparam logic [VAL_W:0] VAL_MIN_X = {2'b11, {(VAL_W - 1){1'b0}}};
    localparam logic [ACC_W-1:0] SUM_MAX_A = {{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0] SUM_MIN_A = {{(ACC_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

    // request kinds
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_ADD_OK   = 2'd0,
        ST_ADD_DROP = 2'd1,
        ST_QUERY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } t_state;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               clr;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               is_query;
        logic [COORD_W-1:0] coord_a;
        logic [COORD_W-1:0] coord_b;
        logic [COORD_W-1:0] value;
        logic [ADDR_W-1:0]  new_addr;
    } t_cell_ctl;

    // word passed from cell to cell
    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             hit;
    } t_chain;

endpackage

@@ hdl/sparse_point_range_sum_top.sv @@
// Top level of the sparse point range-sum block: sequencer, chain of store
// cells and output register. Depends on sprs_pkg and sprs_cell.
//
// Use:
//   s_axis carries one request word: tuser is the request kind (add or
//   range query), tdata holds coord_a, coord_b and add_value. m_axis returns
//   one word per request: tdata is range_sum (zero for adds), tuser is the
//   status (add taken, add dropped because the store is full, query answered).
//   Points live in a row of N_CELLS cells, each owning a bank of BANK_D
//   entries. Every request scans all banks in parallel (one read per cell per
//   cycle), then the partial sums and match flags ripple through the cell
//   chain (S_WAIT), then the S_DONE state resolves the answer and, for a new
//   coordinate, writes the entry. One request is worked at a time.
//   Reset (synchronous, active low) empties the store by clearing the point
//   count; bank contents are not cleared. A stalled receiver holds the result
//   in the output register; the next request may still be accepted and
//   scanned, and waits for the register to drain before it completes.
module sparse_point_range_sum_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sprs_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // coord_a, coord_b, add_value
    input  logic                               s_axis_tuser,   // req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sprs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // range_sum, zero pad
    output logic [sprs_pkg::STAT_W-1:0]        m_axis_tuser    // status
);

    localparam int WAIT_N = sprs_pkg::N_CELLS + 2;
    localparam int WAIT_W = $clog2(WAIT_N + 1);

    sprs_pkg::t_state              r_state, n_state;
    logic [sprs_pkg::ADDR_W-1:0]   r_addr;
    logic [WAIT_W-1:0]             r_wait;
    logic [sprs_pkg::CNT_W-1:0]    r_count;
    logic                          r_is_query;
    logic [sprs_pkg::COORD_W-1:0]  r_coord_a;
    logic [sprs_pkg::COORD_W-1:0]  r_coord_b;
    logic [sprs_pkg::COORD_W-1:0]  r_value;
    logic                          r_out_valid;
    logic [sprs_pkg::SUM_W-1:0]    r_out_sum;
    sprs_pkg::t_status             r_out_status;

    logic                          w_accept;
    logic                          w_finish;
    logic                          w_new_we;
    logic                          w_full;
    logic [sprs_pkg::SUM_W-1:0]    w_sum_sat;
    sprs_pkg::t_status             w_status;
    sprs_pkg::t_cell_ctl           w_ctl;
    sprs_pkg::t_chain              w_chain [sprs_pkg::N_CELLS + 1];
    sprs_pkg::t_chain              w_last;

    assign w_full = (r_count == sprs_pkg::CNT_W'(sprs_pkg::MAX_POINTS));
    assign w_last = w_chain[sprs_pkg::N_CELLS];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sprs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_finish      = 1'b0;
        unique case (r_state)
            sprs_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = sprs_pkg::S_SCAN;
                end
            end
            sprs_pkg::S_SCAN: begin
                if (r_addr == sprs_pkg::ADDR_W'(sprs_pkg::BANK_D - 1)) begin
                    n_state = sprs_pkg::S_WAIT;
                end
            end
            sprs_pkg::S_WAIT: begin
                if (r_wait == WAIT_W'(WAIT_N - 1)) begin
                    n_state = sprs_pkg::S_DONE;
                end
            end
            sprs_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_finish = 1'b1;
                    n_state  = sprs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sprs_pkg::S_IDLE;
            end
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_wait <= '0;
        end else begin
            if (r_state == sprs_pkg::S_SCAN) begin
                r_addr <= r_addr + 1'b1;
            end else begin
                r_addr <= '0;
            end
            if (r_state == sprs_pkg::S_WAIT) begin
                r_wait <= r_wait + 1'b1;
            end else begin
                r_wait <= '0;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_query <= (s_axis_tuser == sprs_pkg::REQ_QUERY);
            r_coord_a  <= s_axis_tdata[sprs_pkg::COORD_W-1:0];
            r_coord_b  <= s_axis_tdata[2*sprs_pkg::COORD_W-1:sprs_pkg::COORD_W];
            r_value    <= s_axis_tdata[3*sprs_pkg::COORD_W-1:2*sprs_pkg::COORD_W];
        end
    end

    // answer resolution
    always_comb begin
        if ($signed(w_last.sum) > $signed(sprs_pkg::SUM_MAX_A)) begin
            w_sum_sat = sprs_pkg::SUM_MAX_A[sprs_pkg::SUM_W-1:0];
        end else if ($signed(w_last.sum) < $signed(sprs_pkg::SUM_MIN_A)) begin
            w_sum_sat = sprs_pkg::SUM_MIN_A[sprs_pkg::SUM_W-1:0];
        end else begin
            w_sum_sat = w_last.sum[sprs_pkg::SUM_W-1:0];
        end

        w_new_we = 1'b0;
        if (r_is_query) begin
            w_status = sprs_pkg::ST_QUERY;
        end else if (w_last.hit) begin
            w_status = sprs_pkg::ST_ADD_OK;
        end else if (w_full) begin
            w_status = sprs_pkg::ST_ADD_DROP;
        end else begin
            w_status = sprs_pkg::ST_ADD_OK;
            w_new_we = w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_new_we) begin
            r_count <= r_count + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_sum    <= r_is_query ? w_sum_sat : '0;
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(sprs_pkg::OUT_DATA_W - sprs_pkg::SUM_W){1'b0}}, r_out_sum};
    assign m_axis_tuser  = r_out_status;

    // broadcast control to the cells
    always_comb begin
        w_ctl.clr      = w_accept;
        w_ctl.rd_en    = (r_state == sprs_pkg::S_SCAN);
        w_ctl.rd_addr  = r_addr;
        w_ctl.is_query = r_is_query;
        w_ctl.coord_a  = r_coord_a;
        w_ctl.coord_b  = r_coord_b;
        w_ctl.value    = r_value;
        w_ctl.new_addr = r_count[sprs_pkg::ADDR_W-1:0];
    end

    assign w_chain[0] = '0;

    // cell row; cell k holds global entries k*BANK_D .. k*BANK_D + BANK_D - 1
    for (genvar k = 0; k < sprs_pkg::N_CELLS; k++) begin : g_cell
        localparam logic [sprs_pkg::CNT_W-1:0] BASE = sprs_pkg::CNT_W'(k * sprs_pkg::BANK_D);
        localparam logic [sprs_pkg::CNT_W-1:0] TOP  =
            sprs_pkg::CNT_W'((k + 1) * sprs_pkg::BANK_D);

        logic [sprs_pkg::LIM_W-1:0]    w_lim;
        logic [sprs_pkg::CNT_W-1:0]    w_rel;
        logic                          w_we;

        always_comb begin
            w_rel = r_count - BASE;
            if (r_count >= TOP) begin
                w_lim = sprs_pkg::LIM_W'(sprs_pkg::BANK_D);
            end else if (r_count > BASE) begin
                w_lim = w_rel[sprs_pkg::LIM_W-1:0];
            end else begin
                w_lim = '0;
            end
            w_we = w_new_we
                && (r_count[sprs_pkg::CNT_W-1:sprs_pkg::ADDR_W] == sprs_pkg::SEL_W'(k));
        end

        sprs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_lim    (w_lim),
            .i_new_we (w_we),
            .i_chain  (w_chain[k]),
            .o_chain  (w_chain[k+1])
        );
    end

endmodule

@@ hdl/sprs_cell.sv @@
// One cell of the store chain: a bank of points, its scan compare and a
// link stage that adds its partial sum into the word from its left neighbor.
// Depends on sprs_pkg.
module sprs_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sprs_pkg::t_cell_ctl      i_ctl,
    input  logic [sprs_pkg::LIM_W-1:0] i_lim,     // entries held in this bank
    input  logic                     i_new_we,
    input  sprs_pkg::t_chain         i_chain,
    output sprs_pkg::t_chain         o_chain
);

    logic [sprs_pkg::COORD_W-1:0] r_coord_mem [sprs_pkg::BANK_D];
    logic [sprs_pkg::VAL_W-1:0]   r_val_mem   [sprs_pkg::BANK_D];

    logic [sprs_pkg::COORD_W-1:0] r_rd_coord;
    logic [sprs_pkg::VAL_W-1:0]   r_rd_val;
    logic [sprs_pkg::ADDR_W-1:0]  r_rd_addr;
    logic                         r_rd_valid;

    logic [sprs_pkg::ACC_W-1:0]   r_acc;
    logic                         r_hit;
    sprs_pkg::t_chain             r_chain;

    logic                         w_match;
    logic                         w_in_rng;
    logic [sprs_pkg::VAL_W:0]     w_wb_sum;
    logic [sprs_pkg::VAL_W-1:0]   w_wb_val;
    logic [sprs_pkg::VAL_W-1:0]   w_new_val;

    // bank read, registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_coord <= r_coord_mem[i_ctl.rd_addr];
            r_rd_val   <= r_val_mem[i_ctl.rd_addr];
            r_rd_addr  <= i_ctl.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_ctl.rd_en && ({1'b0, i_ctl.rd_addr} < i_lim);
        end
    end

    always_comb begin
        w_match  = r_rd_valid && (r_rd_coord == i_ctl.coord_a);
        w_in_rng = r_rd_valid
                && ($signed(r_rd_coord) >= $signed(i_ctl.coord_a))
                && ($signed(r_rd_coord) <= $signed(i_ctl.coord_b));
        w_wb_sum = {r_rd_val[sprs_pkg::VAL_W-1], r_rd_val}
                 + {{(sprs_pkg::VAL_W + 1 - sprs_pkg::COORD_W){i_ctl.value[sprs_pkg::COORD_W-1]}},
                    i_ctl.value};
        if ($signed(w_wb_sum) > $signed(sprs_pkg::VAL_MAX_X)) begin
            w_wb_val = sprs_pkg::VAL_MAX_X[sprs_pkg::VAL_W-1:0];
        end else if ($signed(w_wb_sum) < $signed(sprs_pkg::VAL_MIN_X)) begin
            w_wb_val = sprs_pkg::VAL_MIN_X[sprs_pkg::VAL_W-1:0];
        end else begin
            w_wb_val = w_wb_sum[sprs_pkg::VAL_W-1:0];
        end
        w_new_val = {{(sprs_pkg::VAL_W - sprs_pkg::COORD_W){i_ctl.value[sprs_pkg::COORD_W-1]}},
                     i_ctl.value};
    end

    // bank write: new entry, or accumulate into the matching entry
    always_ff @(posedge i_clk) begin
        if (i_new_we) begin
            r_coord_mem[i_ctl.new_addr] <= i_ctl.coord_a;
            r_val_mem[i_ctl.new_addr]   <= w_new_val;
        end else if (w_match && !i_ctl.is_query) begin
            r_val_mem[r_rd_addr] <= w_wb_val;
        end
    end

    // local partial sum and hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_hit <= 1'b0;
        end else if (i_ctl.clr) begin
            r_acc <= '0;
            r_hit <= 1'b0;
        end else begin
            if (w_in_rng && i_ctl.is_query) begin
                r_acc <= r_acc
                       + {{(sprs_pkg::ACC_W - sprs_pkg::VAL_W){r_rd_val[sprs_pkg::VAL_W-1]}},
                          r_rd_val};
            end
            if (w_match) begin
                r_hit <= 1'b1;
            end
        end
    end

    // link to the right neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else begin
            r_chain.sum <= i_chain.sum + r_acc;
            r_chain.hit <= i_chain.hit | r_hit;
        end
    end

    assign o_chain = r_chain;

endmodule

@@ hdl/sprs_chk.sv @@
// Port-level checks for sparse_point_range_sum_top, attached by bind.
// Depends on sprs_pkg.
module sprs_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sprs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [sprs_pkg::STAT_W-1:0]        m_axis_tuser
);

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a request is in work");

    // held result must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // adds report a zero sum
    a_add_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != sprs_pkg::ST_QUERY) |-> (m_axis_tdata == '0))
        else $error("add result carries a nonzero sum");

    // status code range and pad bits
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == sprs_pkg::ST_ADD_OK
                        || m_axis_tuser == sprs_pkg::ST_ADD_DROP
                        || m_axis_tuser == sprs_pkg::ST_QUERY)
                       && (m_axis_tdata[sprs_pkg::OUT_DATA_W-1:sprs_pkg::SUM_W] == '0))
        else $error("bad status code or pad bits");

    // no result and no request pending right out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

endmodule

bind sparse_point_range_sum_top sprs_chk u_sprs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
